// ===== rtl/aorq_pkg.sv =====
// Shared types and constants for the arrival-ordered ready queue.
package aorq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;
    localparam int DEF_TIME_BITS   = 16;
    localparam int COUNT_OUT_BITS  = 5;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } aorq_cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } aorq_status_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } aorq_op_t;

endpackage

// ===== rtl/arrival_ordered_ready_queue.sv =====
// Top level of the arrival-ordered ready queue: cell chain, counter, result register.
//
// Usage: each beat on the s_ channel is one command. s_tuser[0] selects insert (0)
// or pop (1); s_tdata carries process id (low bits) and arrival time above it.
// An insert places the entry after every waiting entry with an equal or earlier
// arrival time; a pop removes the head, which has the earliest arrival.
// Every command gives exactly one result beat on the m_ channel: m_tuser holds
// the status (ok, pop on empty, insert dropped because full) and m_tdata holds
// popped id, popped arrival and the waiting count after the command.
// The result appears in the cycle after the command is accepted.
// Throughput: one command per cycle while no stalled result holds s_tready low; every cell compares
// its own key with the new key in the same cycle and shifts toward its neighbor in one step.
// Stall: a result held by a stalled receiver blocks s_tready until it is taken;
// a result taken in the same cycle lets the next command in at once.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module arrival_ordered_ready_queue
    import aorq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // process_id, arrival_time
    input  logic [((ID_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // popped_id, popped_arrival, waiting_count
    output logic [((ID_BITS+TIME_BITS+COUNT_OUT_BITS+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0] m_tuser
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W    = ((ID_BITS + TIME_BITS + COUNT_OUT_BITS + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - (ID_BITS + TIME_BITS + COUNT_OUT_BITS);

    logic [TIME_BITS-1:0] cell_key   [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   cell_id    [QUEUE_DEPTH];
    logic                 cell_valid [QUEUE_DEPTH];
    logic                 cell_after [QUEUE_DEPTH];

    logic                 accept;
    aorq_cmd_t            cmd;
    logic [ID_BITS-1:0]   in_id;
    logic [TIME_BITS-1:0] in_key;
    logic                 full;
    logic                 empty;
    aorq_op_t             op;

    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS+COUNT_OUT_BITS-1:0] count_ext;

    logic                 out_valid_reg;
    aorq_status_t         status_reg, status_next;
    logic [ID_BITS-1:0]   pid_reg, pid_next;
    logic [TIME_BITS-1:0] pkey_reg, pkey_next;
    logic [COUNT_OUT_BITS-1:0] wait_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = aorq_cmd_t'(s_tuser[0]);
    assign in_id    = s_tdata[ID_BITS-1:0];
    assign in_key   = s_tdata[ID_BITS +: TIME_BITS];
    assign full     = cell_valid[QUEUE_DEPTH-1];
    assign empty    = !cell_valid[0];

    always_comb begin
        op          = '0;
        count_next  = count_reg;
        status_next = ST_OK;
        pid_next    = '0;
        pkey_next   = '0;
        case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op.insert  = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    op.pop     = accept;
                    count_next = count_reg - 1'b1;
                    pid_next   = cell_id[0];
                    pkey_next  = cell_key[0];
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    assign count_ext = {{COUNT_OUT_BITS{1'b0}}, count_next};

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [TIME_BITS-1:0] p_key, n_key;
        logic [ID_BITS-1:0]   p_id, n_id;
        logic                 p_valid, p_after, n_valid;

        if (i == 0) begin : g_head
            assign p_key   = '0;
            assign p_id    = '0;
            assign p_valid = 1'b0;
            assign p_after = 1'b1;
        end else begin : g_body
            assign p_key   = cell_key[i-1];
            assign p_id    = cell_id[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_after = cell_after[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign n_key   = '0;
            assign n_id    = '0;
            assign n_valid = 1'b0;
        end else begin : g_link
            assign n_key   = cell_key[i+1];
            assign n_id    = cell_id[i+1];
            assign n_valid = cell_valid[i+1];
        end

        aorq_cell #(
            .ID_BITS   (ID_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .new_key    (in_key),
            .new_id     (in_id),
            .prev_key   (p_key),
            .prev_id    (p_id),
            .prev_valid (p_valid),
            .prev_after (p_after),
            .next_key   (n_key),
            .next_id    (n_id),
            .next_valid (n_valid),
            .key        (cell_key[i]),
            .id         (cell_id[i]),
            .valid      (cell_valid[i]),
            .after      (cell_after[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            pid_reg    <= pid_next;
            pkey_reg   <= pkey_next;
            wait_reg   <= count_ext[COUNT_OUT_BITS-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, wait_reg, pkey_reg, pid_reg};

endmodule

// ===== rtl/aorq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module aorq_cell
    import aorq_pkg::*;
#(
    parameter int ID_BITS   = DEF_ID_BITS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  aorq_op_t             op,
    input  logic [TIME_BITS-1:0] new_key,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [TIME_BITS-1:0] prev_key,
    input  logic [ID_BITS-1:0]   prev_id,
    input  logic                 prev_valid,
    input  logic                 prev_after,
    input  logic [TIME_BITS-1:0] next_key,
    input  logic [ID_BITS-1:0]   next_id,
    input  logic                 next_valid,
    output logic [TIME_BITS-1:0] key,
    output logic [ID_BITS-1:0]   id,
    output logic                 valid,
    output logic                 after
);

    logic [TIME_BITS-1:0] key_reg, key_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic                 valid_reg, valid_next;

    assign after = valid_reg && (key_reg <= new_key);

    always_comb begin
        key_next   = key_reg;
        id_next    = id_reg;
        valid_next = valid_reg;
        if (op.insert) begin
            if (!after) begin
                if (prev_after) begin
                    key_next   = new_key;
                    id_next    = new_id;
                    valid_next = 1'b1;
                end else begin
                    key_next   = prev_key;
                    id_next    = prev_id;
                    valid_next = prev_valid;
                end
            end
        end else if (op.pop) begin
            key_next   = next_key;
            id_next    = next_id;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        id_reg  <= id_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key   = key_reg;
    assign id    = id_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/aorq_check.sv =====
// Port-level checker for the arrival-ordered ready queue and its bind.
module aorq_check
    import aorq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((ID_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((ID_BITS+TIME_BITS+COUNT_OUT_BITS+7)/8)*8-1:0] m_tdata,
    input logic [1:0] m_tuser
);

    localparam logic [COUNT_OUT_BITS-1:0] FULL_CNT = COUNT_OUT_BITS'(QUEUE_DEPTH);

    logic [COUNT_OUT_BITS-1:0] waiting;
    logic [ID_BITS+TIME_BITS-1:0] popped;

    assign waiting = m_tdata[ID_BITS+TIME_BITS +: COUNT_OUT_BITS];
    assign popped  = m_tdata[ID_BITS+TIME_BITS-1:0];

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL))
        else $error("result status code out of range");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> waiting == '0 && popped == '0)
        else $error("empty pop reports entries or data");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> waiting == FULL_CNT && popped == '0)
        else $error("dropped insert reports wrong count or data");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind arrival_ordered_ready_queue aorq_check #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TIME_BITS   (TIME_BITS)
) u_aorq_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
